// File: hdl/kwmh_pkg.sv
// kwmh_pkg: shared types and constants of the k-way min-heap merger
// no dependencies; imported by the heap memory, the sequencer, the top level and the checker

package kwmh_pkg;

  // run number width, fixed by the item format
  localparam int unsigned RUN_W = 4;

  // item kinds carried on the input tuser
  localparam logic FUNC_FILL = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  // status of one pop result
  typedef struct packed {
    logic             valid_res;
    logic             last;
    logic [RUN_W-1:0] run;
  } res_flags_t;

endpackage

// File: hdl/kwmh_heap_mem.sv
// kwmh_heap_mem: heap storage, one write port and two registered read ports
// depends on kwmh_pkg for the run width

module kwmh_heap_mem #(
  parameter int unsigned WAYS     = 16,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [$clog2(WAYS)-1:0]               waddr_i,
  input  logic [KEY_BITS+kwmh_pkg::RUN_W-1:0]   wdata_i,
  input  logic [$clog2(WAYS)-1:0]               raddr_a_i,
  input  logic [$clog2(WAYS)-1:0]               raddr_b_i,
  output logic [KEY_BITS+kwmh_pkg::RUN_W-1:0]   rdata_a_o,
  output logic [KEY_BITS+kwmh_pkg::RUN_W-1:0]   rdata_b_o
);
  import kwmh_pkg::*;

  localparam int unsigned ENT_W = KEY_BITS + RUN_W;

  logic [ENT_W-1:0] mem [WAYS];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // two read ports, both registered
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

// File: hdl/kwmh_seq.sv
// kwmh_seq: heap sequencer, sift-up on insert and sift-down on pop
// depends on kwmh_pkg; drives the ports of kwmh_heap_mem

module kwmh_seq #(
  parameter int unsigned WAYS     = 16,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // incoming item
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  in_func_i,
  input  logic [KEY_BITS-1:0]                   in_key_i,
  input  logic [kwmh_pkg::RUN_W-1:0]            in_run_i,
  input  logic                                  in_present_i,
  // pop result
  output logic                                  res_valid_o,
  input  logic                                  res_ready_i,
  output logic [KEY_BITS-1:0]                   res_key_o,
  output kwmh_pkg::res_flags_t                  res_flags_o,
  // heap memory
  output logic                                  mem_we_o,
  output logic [$clog2(WAYS)-1:0]               mem_waddr_o,
  output logic [KEY_BITS+kwmh_pkg::RUN_W-1:0]   mem_wdata_o,
  output logic [$clog2(WAYS)-1:0]               mem_raddr_a_o,
  output logic [$clog2(WAYS)-1:0]               mem_raddr_b_o,
  input  logic [KEY_BITS+kwmh_pkg::RUN_W-1:0]   mem_rdata_a_i,
  input  logic [KEY_BITS+kwmh_pkg::RUN_W-1:0]   mem_rdata_b_i
);
  import kwmh_pkg::*;

  localparam int unsigned ENT_W = KEY_BITS + RUN_W;
  localparam int unsigned IDX_W = $clog2(WAYS);
  localparam int unsigned CNT_W = $clog2(WAYS + 1);
  localparam int unsigned CHL_W = IDX_W + 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_POP_RD,
    S_POP_TOP,
    S_DN_RD,
    S_DN_CMP,
    S_OUT
  } state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   count_q;
  logic [RUN_W-1:0]   last_run_q;
  logic               func_q;
  logic [ENT_W-1:0]   cur_q;
  logic [ENT_W-1:0]   top_q;
  logic [IDX_W-1:0]   idx_q;
  logic               res_vld_q;
  logic               res_last_q;

  // strict order: signed key, then lower run first
  function automatic logic ent_before(logic [ENT_W-1:0] a, logic [ENT_W-1:0] b);
    logic signed [KEY_BITS-1:0] ka;
    logic signed [KEY_BITS-1:0] kb;
    ka = a[ENT_W-1:RUN_W];
    kb = b[ENT_W-1:RUN_W];
    return (ka < kb) || ((ka == kb) && (a[RUN_W-1:0] < b[RUN_W-1:0]));
  endfunction

  logic [IDX_W-1:0] parent;
  logic [CHL_W-1:0] left_w;
  logic [CHL_W-1:0] right_w;
  logic [CHL_W-1:0] count_w;
  logic             left_ok;
  logic             right_ok;
  logic             up_swap;
  logic             take_l;
  logic             take_r;
  logic [ENT_W-1:0] best_lc;
  logic [IDX_W-1:0] child;
  logic             accept;
  logic             ins_ok;

  // tree index arithmetic
  assign parent   = IDX_W'((idx_q - IDX_W'(1)) >> 1);
  assign left_w   = CHL_W'({idx_q, 1'b1});
  assign right_w  = left_w + CHL_W'(1);
  assign count_w  = CHL_W'(count_q);
  assign left_ok  = left_w < count_w;
  assign right_ok = right_w < count_w;

  // sift-up and sift-down compares on registered read data
  assign up_swap = ent_before(cur_q, mem_rdata_a_i);
  assign take_l  = ent_before(mem_rdata_a_i, cur_q);
  assign best_lc = take_l ? mem_rdata_a_i : cur_q;
  assign take_r  = right_ok && ent_before(mem_rdata_b_i, best_lc);
  assign child   = take_r ? right_w[IDX_W-1:0] : left_w[IDX_W-1:0];

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign ins_ok     = in_present_i && (count_q != CNT_W'(WAYS));

  // memory port control
  always_comb begin
    mem_we_o      = 1'b0;
    mem_waddr_o   = idx_q;
    mem_wdata_o   = cur_q;
    mem_raddr_a_o = '0;
    mem_raddr_b_o = '0;
    case (state_q)
      S_UP_RD: begin
        if (idx_q == '0) begin
          mem_we_o = 1'b1;
        end else begin
          mem_raddr_a_o = parent;
        end
      end
      S_UP_CMP: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = up_swap ? mem_rdata_a_i : cur_q;
      end
      S_POP_RD: begin
        mem_raddr_a_o = '0;
        mem_raddr_b_o = IDX_W'(count_q - CNT_W'(1));
      end
      S_DN_RD: begin
        if (!left_ok) begin
          mem_we_o = 1'b1;
        end else begin
          mem_raddr_a_o = left_w[IDX_W-1:0];
          mem_raddr_b_o = right_w[IDX_W-1:0];
        end
      end
      S_DN_CMP: begin
        mem_we_o = 1'b1;
        if (take_r) begin
          mem_wdata_o = mem_rdata_b_i;
        end else if (take_l) begin
          mem_wdata_o = mem_rdata_a_i;
        end
      end
      default: begin
        mem_we_o = 1'b0;
      end
    endcase
  end

  // sequencer state and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      last_run_q <= '0;
      func_q     <= FUNC_FILL;
      cur_q      <= '0;
      top_q      <= '0;
      idx_q      <= '0;
      res_vld_q  <= 1'b0;
      res_last_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            func_q <= in_func_i;
            if (ins_ok) begin
              cur_q   <= {in_key_i, (in_func_i == FUNC_POP) ? last_run_q : in_run_i};
              idx_q   <= count_q[IDX_W-1:0];
              count_q <= count_q + CNT_W'(1);
              state_q <= S_UP_RD;
            end else if (in_func_i == FUNC_POP) begin
              state_q <= S_POP_RD;
            end
          end
        end
        S_UP_RD: begin
          if (idx_q == '0) begin
            state_q <= (func_q == FUNC_POP) ? S_POP_RD : S_IDLE;
          end else begin
            state_q <= S_UP_CMP;
          end
        end
        S_UP_CMP: begin
          if (up_swap) begin
            idx_q   <= parent;
            state_q <= S_UP_RD;
          end else begin
            state_q <= (func_q == FUNC_POP) ? S_POP_RD : S_IDLE;
          end
        end
        S_POP_RD: begin
          if (count_q == '0) begin
            top_q      <= '0;
            res_vld_q  <= 1'b0;
            res_last_q <= 1'b1;
            state_q    <= S_OUT;
          end else begin
            count_q <= count_q - CNT_W'(1);
            state_q <= S_POP_TOP;
          end
        end
        S_POP_TOP: begin
          top_q      <= mem_rdata_a_i;
          last_run_q <= mem_rdata_a_i[RUN_W-1:0];
          cur_q      <= mem_rdata_b_i;
          idx_q      <= '0;
          res_vld_q  <= 1'b1;
          res_last_q <= (count_q == '0);
          state_q    <= (count_q == '0) ? S_OUT : S_DN_RD;
        end
        S_DN_RD: begin
          state_q <= left_ok ? S_DN_CMP : S_OUT;
        end
        S_DN_CMP: begin
          if (take_l || take_r) begin
            idx_q   <= child;
            state_q <= S_DN_RD;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign res_valid_o           = (state_q == S_OUT);
  assign res_key_o             = top_q[ENT_W-1:RUN_W];
  assign res_flags_o.valid_res = res_vld_q;
  assign res_flags_o.last      = res_last_q;
  assign res_flags_o.run       = top_q[RUN_W-1:0];

endmodule

// File: hdl/kway_min_heap_merger.sv
// k-way merge min-heap: one item at a time, heap in a registered dual-read memory
// fill: each parent compared is read, then compared and written, plus a root write if the
// key climbs that far, and tready stays low until the climb ends; pop: that refill climb,
// a read of root and tail, a load of both unless the heap is empty; per child pair a read,
// then a compare and write, plus a write to place at a leaf; then the output register loads
// rst_ni clears the heap count and last popped run; heap memory is not cleared

module kway_min_heap_merger #(
  parameter int unsigned WAYS     = 16,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  // input stream
  input  logic                                              s_axis_tvalid_i,
  output logic                                              s_axis_tready_o,
  // tdata fields from bit 0: key, run, present, zero fill
  input  logic [((KEY_BITS+kwmh_pkg::RUN_W+1+7)/8)*8-1:0]   s_axis_tdata_i,
  // tuser fields from bit 0: func
  input  logic                                              s_axis_tuser_i,
  // output stream
  output logic                                              m_axis_tvalid_o,
  input  logic                                              m_axis_tready_i,
  // tdata fields from bit 0: out_key, out_run, zero fill
  output logic [((KEY_BITS+kwmh_pkg::RUN_W+7)/8)*8-1:0]     m_axis_tdata_o,
  // tuser fields from bit 0: valid_res
  output logic                                              m_axis_tuser_o,
  output logic                                              m_axis_tlast_o
);
  import kwmh_pkg::*;

  localparam int unsigned ENT_W      = KEY_BITS + RUN_W;
  localparam int unsigned IDX_W      = $clog2(WAYS);
  localparam int unsigned OUT_DATA_W = ((KEY_BITS + RUN_W + 7) / 8) * 8;

  logic                  res_valid;
  logic                  res_ready;
  logic [KEY_BITS-1:0]   res_key;
  res_flags_t            res_flags;

  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [ENT_W-1:0]      mem_wdata;
  logic [IDX_W-1:0]      mem_raddr_a;
  logic [IDX_W-1:0]      mem_raddr_b;
  logic [ENT_W-1:0]      mem_rdata_a;
  logic [ENT_W-1:0]      mem_rdata_b;

  logic                  out_valid_q;
  logic [KEY_BITS-1:0]   out_key_q;
  res_flags_t            out_flags_q;

  // heap sequencer
  kwmh_seq #(
    .WAYS     (WAYS),
    .KEY_BITS (KEY_BITS)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .in_func_i     (s_axis_tuser_i),
    .in_key_i      (s_axis_tdata_i[KEY_BITS-1:0]),
    .in_run_i      (s_axis_tdata_i[ENT_W-1:KEY_BITS]),
    .in_present_i  (s_axis_tdata_i[ENT_W]),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_key_o     (res_key),
    .res_flags_o   (res_flags),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_raddr_a_o (mem_raddr_a),
    .mem_raddr_b_o (mem_raddr_b),
    .mem_rdata_a_i (mem_rdata_a),
    .mem_rdata_b_i (mem_rdata_b)
  );

  // heap storage
  kwmh_heap_mem #(
    .WAYS     (WAYS),
    .KEY_BITS (KEY_BITS)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_a_o (mem_rdata_a),
    .rdata_b_o (mem_rdata_b)
  );

  // output register, loads when empty or being drained
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_key_q   <= res_key;
      out_flags_q <= res_flags;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_DATA_W'({out_flags_q.run, out_key_q});
  assign m_axis_tuser_o  = out_flags_q.valid_res;
  assign m_axis_tlast_o  = out_flags_q.last;

endmodule

// File: hdl/kwmh_checker.sv
// kwmh_checker: port-level assertions for kway_min_heap_merger, bound below
// depends on kwmh_pkg and the top level's port list

module kwmh_checker #(
  parameter int unsigned WAYS     = 16,
  parameter int unsigned KEY_BITS = 32
) (
  input logic                                              clk_i,
  input logic                                              rst_ni,
  input logic                                              s_axis_tvalid_i,
  input logic                                              s_axis_tready_o,
  // tdata fields from bit 0: key, run, present, zero fill
  input logic [((KEY_BITS+kwmh_pkg::RUN_W+1+7)/8)*8-1:0]   s_axis_tdata_i,
  // tuser fields from bit 0: func
  input logic                                              s_axis_tuser_i,
  input logic                                              m_axis_tvalid_o,
  input logic                                              m_axis_tready_i,
  // tdata fields from bit 0: out_key, out_run, zero fill
  input logic [((KEY_BITS+kwmh_pkg::RUN_W+7)/8)*8-1:0]     m_axis_tdata_o,
  // tuser fields from bit 0: valid_res
  input logic                                              m_axis_tuser_o,
  input logic                                              m_axis_tlast_o
);
  import kwmh_pkg::*;

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
      && $stable(m_axis_tlast_o))
    else $error("output payload changed while stalled");

  // a pop from an empty heap reports an empty heap
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tlast_o)
    else $error("empty pop without last");

  // a pop from an empty heap carries zero key and run
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("empty pop with nonzero data");

  // an accepted pop keeps the input closed for the next cycle
  a_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == FUNC_POP) |=>
      !s_axis_tready_o)
    else $error("input open right after a pop transfer");

endmodule

bind kway_min_heap_merger kwmh_checker #(
  .WAYS     (WAYS),
  .KEY_BITS (KEY_BITS)
) u_kwmh_checker (.*);
